// ===== sv/box_blur_3x3_stream_top_assert.svh =====
// assertion macros used by the box blur port checker
`ifndef BOX_BLUR_3X3_STREAM_TOP_ASSERT_SVH
`define BOX_BLUR_3X3_STREAM_TOP_ASSERT_SVH

// property checked on every clock while out of reset
`define BB3_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// consequence checked in the clock after the antecedent
`define BB3_ASSERT_NEXT(lbl, ante, cons, msg) \
  `BB3_ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

// ===== sv/bb3_pkg.sv =====
// types, codes and constants of the 3x3 box blur
package bb3_pkg;

  // config port
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 13;
  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 4'd1;

  // register and field widths
  localparam int FwW     = 11;
  localparam int FhW     = 13;
  localparam int RowW    = 12;
  localparam int ColOutW = 10;
  localparam logic [FwW-1:0] FwReset = 11'd1024;
  localparam logic [FhW-1:0] FhReset = 13'd1;
  localparam logic [FhW-1:0] MaxHeight = 13'd4096;

  // item opcodes
  localparam logic OpPixel = 1'b0;
  localparam logic OpDrain = 1'b1;

  // reciprocal scaling for the rounded mean
  localparam int CntW       = 4;
  localparam int NumW       = 13;
  localparam int RecipW     = 17;
  localparam int RecipShift = 17;
  localparam int ProdW      = NumW + RecipW;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_t;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StSum,
    StMul,
    StOut,
    StDrd,
    StDcap
  } state_e;

  // ceil(2^17 / (2*cnt)); exact quotient for numerators below 4600
  function automatic logic [RecipW-1:0] recip(input logic [CntW-1:0] cnt);
    logic [RecipW-1:0] m;
    unique case (cnt)
      4'd1:    m = 17'd65536;
      4'd2:    m = 17'd32768;
      4'd3:    m = 17'd21846;
      4'd4:    m = 17'd16384;
      4'd6:    m = 17'd10923;
      4'd9:    m = 17'd7282;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/box_blur_3x3_stream_top.sv =====
// streaming 3x3 box blur with two row stores and a 3x3 window
// pixel word: zero, one or two results, each through the sum, multiply and output states;
// next word taken once the sequencer is back in idle, after the load state or the last result
// drain word: n = 1..3 columns read from the single-port row stores, then one result
// reset: width 1024, height 1, frame restarted; row store contents undefined
module box_blur_3x3_stream_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             opcode_i,
  input  logic [7:0]                       red_in_i,
  input  logic [7:0]                       green_in_i,
  input  logic [7:0]                       blue_in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [7:0]                       red_out_o,
  output logic [7:0]                       green_out_o,
  output logic [7:0]                       blue_out_o,
  output logic [bb3_pkg::RowW-1:0]         out_row_o,
  output logic [bb3_pkg::ColOutW-1:0]      out_col_o,
  output logic                             frame_done_o,
  output logic                             run_last_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bb3_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [bb3_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int AW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int RowW    = bb3_pkg::RowW;
  localparam int ColOutW = bb3_pkg::ColOutW;
  localparam int FhW     = bb3_pkg::FhW;
  localparam int NumW    = bb3_pkg::NumW;
  localparam int CntW    = bb3_pkg::CntW;
  localparam int ProdW   = bb3_pkg::ProdW;

  bb3_pkg::state_e state_q, state_d;

  // config and frame position
  logic [bb3_pkg::FwW-1:0] fw_q;
  logic [FhW-1:0]          fh_q;
  logic [RowW-1:0]         row_q;
  logic [AW-1:0]           col_q;
  logic [AW-1:0]           dpos_q;
  logic                    loaded_q;

  logic [WW-1:0]  w_eff, w_m1, dpos_p1;
  logic [FhW-1:0] h_eff, h_m1;
  logic           h_ge2, col_last, row_last, dpos_last;

  // per-item control
  logic drain_q, pend_a_q, pend_b_q, out_valid_q;

  // payload registers
  bb3_pkg::pix_t   px_q;
  logic [RowW-1:0] r_q;
  logic [AW-1:0]   c_q, d_q, dx_q, dhi_q;
  logic [2:0]      dcm_q;
  bb3_pkg::pix_t   win_q [3][3];

  // row stores
  bb3_pkg::pix_t up_mem  [MAX_WIDTH];
  bb3_pkg::pix_t mid_mem [MAX_WIDTH];
  bb3_pkg::pix_t up_rd_q, mid_rd_q;
  logic [AW-1:0] up_addr, mid_addr;
  logic          up_we, mid_we;

  // reduce and divide path
  logic [NumW-1:0]    n_q [3];
  logic [CntW-1:0]    cnt_q;
  logic [ProdW-1:0]   prod_q [3];
  logic [RowW-1:0]    orow_q;
  logic [ColOutW-1:0] ocol_q;
  logic               odone_q, olast_q;

  logic            in_fire, cfg_fire, px_fire, dr_fire, out_free;
  logic            c_last_q, res_a, res_b;
  logic [2:0]      cm, rm;
  logic [11:0]     sr, sg, sb;
  logic [CntW-1:0] cnt_c;
  logic [RowW-1:0] row_c;
  logic [AW-1:0]   col_c;
  logic            done_c, last_c;
  logic [AW-1:0]   lo_c, hi_c;

  // effective frame size, saturated
  always_comb begin
    if (fw_q == '0) begin
      w_eff = WW'(1);
    end else if (int'(fw_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_q);
    end
    if (fh_q == '0) begin
      h_eff = FhW'(1);
    end else if (fh_q > bb3_pkg::MaxHeight) begin
      h_eff = bb3_pkg::MaxHeight;
    end else begin
      h_eff = fh_q;
    end
  end

  assign w_m1      = w_eff - WW'(1);
  assign h_m1      = h_eff - FhW'(1);
  assign h_ge2     = (h_eff > FhW'(1));
  assign col_last  = (WW'(col_q) == w_m1);
  assign row_last  = (FhW'(row_q) == h_m1);
  assign dpos_last = (WW'(dpos_q) == w_m1);
  assign dpos_p1   = WW'(dpos_q) + WW'(1);
  assign lo_c      = (dpos_q == '0) ? '0 : dpos_q - AW'(1);
  assign hi_c      = (dpos_p1 < w_eff) ? AW'(dpos_p1) : AW'(w_m1);
  assign c_last_q  = (WW'(c_q) == w_m1);
  assign res_a     = (r_q != '0) && (c_q != '0);
  assign res_b     = (r_q != '0) && c_last_q;

  assign in_ready_o  = (state_q == bb3_pkg::StIdle) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == bb3_pkg::StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign px_fire     = in_fire && (opcode_i == bb3_pkg::OpPixel) && !loaded_q;
  assign dr_fire     = in_fire && (opcode_i == bb3_pkg::OpDrain) && loaded_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // config registers and frame position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q     <= bb3_pkg::FwReset;
      fh_q     <= bb3_pkg::FhReset;
      row_q    <= '0;
      col_q    <= '0;
      dpos_q   <= '0;
      loaded_q <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        bb3_pkg::CfgFrameWidth:  fw_q <= cfg_data_i[bb3_pkg::FwW-1:0];
        bb3_pkg::CfgFrameHeight: fh_q <= cfg_data_i;
        default: ;
      endcase
      if (cfg_index_i == bb3_pkg::CfgFrameWidth ||
          cfg_index_i == bb3_pkg::CfgFrameHeight) begin
        row_q    <= '0;
        col_q    <= '0;
        dpos_q   <= '0;
        loaded_q <= 1'b0;
      end
    end else if (px_fire) begin
      if (col_last) begin
        col_q <= '0;
        if (row_last) begin
          row_q    <= '0;
          dpos_q   <= '0;
          loaded_q <= 1'b1;
        end else begin
          row_q <= row_q + RowW'(1);
        end
      end else begin
        col_q <= col_q + AW'(1);
      end
    end else if (dr_fire) begin
      if (dpos_last) begin
        row_q    <= '0;
        col_q    <= '0;
        dpos_q   <= '0;
        loaded_q <= 1'b0;
      end else begin
        dpos_q <= dpos_q + AW'(1);
      end
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bb3_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bb3_pkg::StIdle: begin
        if (px_fire) begin
          state_d = bb3_pkg::StLoad;
        end else if (dr_fire) begin
          state_d = bb3_pkg::StDrd;
        end
      end
      bb3_pkg::StLoad: begin
        state_d = (res_a || res_b) ? bb3_pkg::StSum : bb3_pkg::StIdle;
      end
      bb3_pkg::StSum: state_d = bb3_pkg::StMul;
      bb3_pkg::StMul: state_d = bb3_pkg::StOut;
      bb3_pkg::StOut: begin
        if (out_free) begin
          state_d = (pend_a_q || pend_b_q) ? bb3_pkg::StSum : bb3_pkg::StIdle;
        end
      end
      bb3_pkg::StDrd:  state_d = bb3_pkg::StDcap;
      bb3_pkg::StDcap: begin
        state_d = (dx_q == dhi_q) ? bb3_pkg::StSum : bb3_pkg::StDrd;
      end
      default: state_d = bb3_pkg::StIdle;
    endcase
  end

  // which results are still owed for the current word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q  <= 1'b0;
      pend_a_q <= 1'b0;
      pend_b_q <= 1'b0;
    end else begin
      if (in_fire) begin
        drain_q <= dr_fire;
      end
      if (state_q == bb3_pkg::StLoad) begin
        pend_a_q <= res_a;
        pend_b_q <= res_b;
      end else if (state_q == bb3_pkg::StSum) begin
        if (pend_a_q) begin
          pend_a_q <= 1'b0;
        end else begin
          pend_b_q <= 1'b0;
        end
      end
    end
  end

  // row store ports: pixel reads both stores and writes middle at accept, writes upper in the next cycle
  assign mid_we   = px_fire;
  assign mid_addr = (state_q == bb3_pkg::StDrd) ? dx_q : col_q;
  assign up_we    = (state_q == bb3_pkg::StLoad);
  always_comb begin
    if (state_q == bb3_pkg::StLoad) begin
      up_addr = c_q;
    end else if (state_q == bb3_pkg::StDrd) begin
      up_addr = dx_q;
    end else begin
      up_addr = col_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_we) begin
      mid_mem[mid_addr] <= '{r: red_in_i, g: green_in_i, b: blue_in_i};
    end
    mid_rd_q <= mid_mem[mid_addr];
  end

  always_ff @(posedge clk_i) begin
    if (up_we) begin
      up_mem[up_addr] <= mid_rd_q;
    end
    up_rd_q <= up_mem[up_addr];
  end

  // item payload, drain column walk and window
  always_ff @(posedge clk_i) begin
    if (px_fire) begin
      px_q <= '{r: red_in_i, g: green_in_i, b: blue_in_i};
      r_q  <= row_q;
      c_q  <= col_q;
    end
    if (dr_fire) begin
      d_q   <= dpos_q;
      dx_q  <= lo_c;
      dhi_q <= hi_c;
      dcm_q <= '0;
    end
    if (state_q == bb3_pkg::StDcap) begin
      dcm_q <= {1'b1, dcm_q[2:1]};
      if (dx_q != dhi_q) begin
        dx_q <= dx_q + AW'(1);
      end
    end
    if (state_q == bb3_pkg::StLoad || state_q == bb3_pkg::StDcap) begin
      win_q[0]    <= win_q[1];
      win_q[1]    <= win_q[2];
      win_q[2][0] <= up_rd_q;
      win_q[2][1] <= mid_rd_q;
      win_q[2][2] <= (state_q == bb3_pkg::StLoad) ? px_q : '0;
    end
  end

  // window masks and position of the result being formed
  always_comb begin
    if (drain_q) begin
      cm     = dcm_q;
      rm     = {1'b0, 1'b1, h_ge2};
      row_c  = h_m1[RowW-1:0];
      col_c  = d_q;
      done_c = (WW'(d_q) == w_m1);
      last_c = 1'b1;
    end else if (pend_a_q) begin
      cm     = (c_q > AW'(1)) ? 3'b111 : 3'b110;
      rm     = (r_q > RowW'(1)) ? 3'b111 : 3'b110;
      row_c  = r_q - RowW'(1);
      col_c  = c_q - AW'(1);
      done_c = 1'b0;
      last_c = !pend_b_q;
    end else begin
      cm     = (c_q != '0) ? 3'b110 : 3'b100;
      rm     = (r_q > RowW'(1)) ? 3'b111 : 3'b110;
      row_c  = r_q - RowW'(1);
      col_c  = c_q;
      done_c = 1'b0;
      last_c = 1'b1;
    end
  end

  always_comb begin
    sr = '0;
    sg = '0;
    sb = '0;
    for (int x = 0; x < 3; x++) begin
      for (int y = 0; y < 3; y++) begin
        if (cm[x] && rm[y]) begin
          sr = sr + 12'(win_q[x][y].r);
          sg = sg + 12'(win_q[x][y].g);
          sb = sb + 12'(win_q[x][y].b);
        end
      end
    end
    cnt_c = CntW'($countones(cm)) * CntW'($countones(rm));
  end

  // sum -> multiply by reciprocal -> output register
  always_ff @(posedge clk_i) begin
    if (state_q == bb3_pkg::StSum) begin
      n_q[0]  <= {sr, 1'b0} + NumW'(cnt_c);
      n_q[1]  <= {sg, 1'b0} + NumW'(cnt_c);
      n_q[2]  <= {sb, 1'b0} + NumW'(cnt_c);
      cnt_q   <= cnt_c;
      orow_q  <= row_c;
      ocol_q  <= ColOutW'(col_c);
      odone_q <= done_c;
      olast_q <= last_c;
    end
    if (state_q == bb3_pkg::StMul) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= ProdW'(n_q[i]) * ProdW'(bb3_pkg::recip(cnt_q));
      end
    end
    if (state_q == bb3_pkg::StOut && out_free) begin
      red_out_o    <= prod_q[0][bb3_pkg::RecipShift +: 8];
      green_out_o  <= prod_q[1][bb3_pkg::RecipShift +: 8];
      blue_out_o   <= prod_q[2][bb3_pkg::RecipShift +: 8];
      out_row_o    <= orow_q;
      out_col_o    <= ocol_q;
      frame_done_o <= odone_q;
      run_last_o   <= olast_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == bb3_pkg::StOut && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/bb3_check.sv =====
// port checker for the box blur, bound to the top level
`include "box_blur_3x3_stream_top_assert.svh"

module bb3_check (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [7:0]                   red_out_o,
  input logic [7:0]                   green_out_o,
  input logic [7:0]                   blue_out_o,
  input logic [bb3_pkg::RowW-1:0]     out_row_o,
  input logic [bb3_pkg::ColOutW-1:0]  out_col_o,
  input logic                         frame_done_o,
  input logic                         run_last_o,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o
);

  localparam int OutWordW = 3 * 8 + bb3_pkg::RowW + bb3_pkg::ColOutW + 2;

  logic in_fire, cfg_fire;
  logic [OutWordW-1:0] out_word;

  assign in_fire  = in_valid_i && in_ready_o;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;
  assign out_word = {red_out_o, green_out_o, blue_out_o, out_row_o, out_col_o,
                     frame_done_o, run_last_o};

  // a stalled result word keeps its payload
  `BB3_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_word), "result word changed while stalled")

  // the last pixel of a frame always closes its item
  `BB3_ASSERT_CLK(a_done_last, (out_valid_o && frame_done_o) |-> run_last_o, "frame_done without run_last")

  // the second result of a pixel is still owed, so no new word is taken
  `BB3_ASSERT_CLK(a_pair_busy, (out_valid_o && !run_last_o) |-> !in_fire, "input taken while a result pair is open")

  // config and input never land on the same edge
  `BB3_ASSERT_CLK(a_cfg_excl, cfg_fire |-> !in_fire, "config write and input word on one edge")

endmodule

bind box_blur_3x3_stream_top bb3_check u_bb3_check (.*);

// ===== verif/box_blur_3x3_stream_checker.sv =====
// checker for the 3x3 box blur: predicts each blurred pixel and compares the output words
`timescale 1ns / 1ps
module box_blur_3x3_stream_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic                         opcode_i,
  input  logic [7:0]                   red_in_i,
  input  logic [7:0]                   green_in_i,
  input  logic [7:0]                   blue_in_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [7:0]                   red_out_i,
  input  logic [7:0]                   green_out_i,
  input  logic [7:0]                   blue_out_i,
  input  logic [bb3_pkg::RowW-1:0]     out_row_i,
  input  logic [bb3_pkg::ColOutW-1:0]  out_col_i,
  input  logic                         frame_done_i,
  input  logic                         run_last_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [bb3_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bb3_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           fail_count_o,
  output int                           pending_o
);

  localparam int MaxWidth = 1024;
  localparam int MaxRows  = 4096;

  typedef struct packed {
    bb3_pkg::pix_t               px;
    logic [bb3_pkg::RowW-1:0]    row;
    logic [bb3_pkg::ColOutW-1:0] col;
    logic                        done;
    logic                        last;
  } blur_t;

  typedef struct packed {
    int r;
    int g;
    int b;
    int n;
  } sum_t;

  blur_t                   pending_blurs[$];
  bb3_pkg::pix_t           upper_row[MaxWidth];
  bb3_pkg::pix_t           middle_row[MaxWidth];
  bb3_pkg::pix_t           window_px[9];
  logic [bb3_pkg::FwW-1:0] fw_q;
  logic [bb3_pkg::FhW-1:0] fh_q;
  int                      row_q;
  int                      col_q;
  int                      drain_q;
  logic                    loaded_q;
  int                      errors;

  function automatic int active_width();
    if (fw_q == '0) return 1;
    if (fw_q > MaxWidth) return MaxWidth;
    return int'(fw_q);
  endfunction

  function automatic int active_height();
    if (fh_q == '0) return 1;
    if (fh_q > MaxRows) return MaxRows;
    return int'(fh_q);
  endfunction

  function automatic sum_t tally(input sum_t acc, input bb3_pkg::pix_t px);
    sum_t s;
    s = acc;
    s.r = s.r + int'(px.r);
    s.g = s.g + int'(px.g);
    s.b = s.b + int'(px.b);
    s.n = s.n + 1;
    return s;
  endfunction

  // rounded half up: (2*sum + n) / (2*n)
  function automatic blur_t blur_of(input sum_t s, input int row, input int col,
                                    input logic done);
    blur_t res;
    int qr, qg, qb;
    qr = (2 * s.r + s.n) / (2 * s.n);
    qg = (2 * s.g + s.n) / (2 * s.n);
    qb = (2 * s.b + s.n) / (2 * s.n);
    res.px.r = qr[7:0];
    res.px.g = qg[7:0];
    res.px.b = qb[7:0];
    res.row  = row[bb3_pkg::RowW-1:0];
    res.col  = col[bb3_pkg::ColOutW-1:0];
    res.done = done;
    res.last = 1'b0;
    return res;
  endfunction

  // window column x (0 oldest), row y (0 upper, 2 current)
  function automatic blur_t window_blur(input int first_x, input logic top_ok,
                                        input int row, input int col);
    sum_t s;
    int x, y;
    s = '0;
    for (x = first_x; x < 3; x++) begin
      for (y = top_ok ? 0 : 1; y < 3; y++) begin
        s = tally(s, window_px[x*3 + y]);
      end
    end
    return blur_of(s, row, col, 1'b0);
  endfunction

  task automatic restart_frame();
    int i;
    row_q    = 0;
    col_q    = 0;
    drain_q  = 0;
    loaded_q = 1'b0;
    for (i = 0; i < 9; i++) window_px[i] = '0;
  endtask

  task automatic predict_blur(input logic op, input bb3_pkg::pix_t px);
    int w, h, r, c, lo, hi, x, i, n;
    sum_t s;
    bb3_pkg::pix_t up, mid;
    logic done;
    blur_t res[2];
    w = active_width();
    h = active_height();
    n = 0;
    if (op == bb3_pkg::OpDrain) begin
      if (!loaded_q || drain_q >= w) return;
      lo = (drain_q == 0) ? 0 : drain_q - 1;
      hi = (drain_q + 1 < w) ? drain_q + 1 : w - 1;
      s = '0;
      for (x = lo; x <= hi; x++) begin
        if (h >= 2) s = tally(s, upper_row[x]);
        s = tally(s, middle_row[x]);
      end
      done = (drain_q == w - 1);
      res[0] = blur_of(s, h - 1, drain_q, done);
      res[0].last = 1'b1;
      pending_blurs.push_back(res[0]);
      drain_q = drain_q + 1;
      if (done) restart_frame();
      return;
    end
    // pixels are dropped while the last row waits for its drain
    if (loaded_q) return;
    r = row_q;
    c = col_q;
    if (c >= w || r >= h) begin
      restart_frame();
      r = 0;
      c = 0;
    end
    up = upper_row[c];
    mid = middle_row[c];
    upper_row[c] = mid;
    middle_row[c] = px;
    for (i = 0; i < 6; i++) window_px[i] = window_px[i+3];
    window_px[6] = up;
    window_px[7] = mid;
    window_px[8] = px;
    if (r >= 1) begin
      if (c >= 1) begin
        res[n] = window_blur((c >= 2) ? 0 : 1, r >= 2, r - 1, c - 1);
        n++;
      end
      if (c == w - 1) begin
        res[n] = window_blur((c >= 1) ? 1 : 2, r >= 2, r - 1, c);
        n++;
      end
      for (i = 0; i < n; i++) begin
        res[i].last = (i == n - 1);
        pending_blurs.push_back(res[i]);
      end
    end
    if (c + 1 >= w) begin
      col_q = 0;
      if (r + 1 >= h) begin
        row_q    = 0;
        drain_q  = 0;
        loaded_q = 1'b1;
      end else begin
        row_q = r + 1;
      end
    end else begin
      col_q = c + 1;
      row_q = r;
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    blur_t want;
    if (!rst_ni) begin
      fw_q = bb3_pkg::FwReset;
      fh_q = bb3_pkg::FhReset;
      restart_frame();
      pending_blurs.delete();
      errors = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == bb3_pkg::CfgFrameWidth) begin
          fw_q = cfg_data_i[bb3_pkg::FwW-1:0];
          restart_frame();
        end else if (cfg_index_i == bb3_pkg::CfgFrameHeight) begin
          fh_q = cfg_data_i[bb3_pkg::FhW-1:0];
          restart_frame();
        end
      end
      if (in_valid_i && in_ready_i) predict_blur(opcode_i, {red_in_i, green_in_i, blue_in_i});
      if (out_valid_i && out_ready_i) begin
        if (pending_blurs.size() == 0) begin
          errors++;
          $display("%0t: no word expected, got row %0d col %0d rgb %0d %0d %0d", $time,
                   out_row_i, out_col_i, red_out_i, green_out_i, blue_out_i);
        end else begin
          want = pending_blurs.pop_front();
          check_field("red_out", int'(want.px.r), int'(red_out_i));
          check_field("green_out", int'(want.px.g), int'(green_out_i));
          check_field("blue_out", int'(want.px.b), int'(blue_out_i));
          check_field("out_row", int'(want.row), int'(out_row_i));
          check_field("out_col", int'(want.col), int'(out_col_i));
          check_field("frame_done", int'(want.done), int'(frame_done_i));
          check_field("run_last", int'(want.last), int'(run_last_i));
        end
      end
      fail_count_o <= errors;
      pending_o <= pending_blurs.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
// top of the box blur testbench: clock, reset, stimulus, output stalls and verdict
`timescale 1ns / 1ps
module tb;

  localparam int IdxW         = bb3_pkg::CfgIdxW;
  localparam int DataW        = bb3_pkg::CfgDataW;
  localparam int SettleCycles = 20;
  localparam int RandomWords  = 560;
  localparam int LastCfgIdx   = (1 << IdxW) - 1;

  logic                        clk_i;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic                        opcode_i = bb3_pkg::OpPixel;
  logic [7:0]                  red_in_i = '0;
  logic [7:0]                  green_in_i = '0;
  logic [7:0]                  blue_in_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [7:0]                  red_out_o;
  logic [7:0]                  green_out_o;
  logic [7:0]                  blue_out_o;
  logic [bb3_pkg::RowW-1:0]    out_row_o;
  logic [bb3_pkg::ColOutW-1:0] out_col_o;
  logic                        frame_done_o;
  logic                        run_last_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [IdxW-1:0]             cfg_index_i = '0;
  logic [DataW-1:0]            cfg_data_i = '0;

  int fail_count;
  int pending;
  int words_sent;
  bit burst;

  box_blur_3x3_stream_top i_dut (.*);

  box_blur_3x3_stream_checker i_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i   (in_ready_o),
    .opcode_i,
    .red_in_i,
    .green_in_i,
    .blue_in_i,
    .out_valid_i  (out_valid_o),
    .out_ready_i,
    .red_out_i    (red_out_o),
    .green_out_i  (green_out_o),
    .blue_out_i   (blue_out_o),
    .out_row_i    (out_row_o),
    .out_col_i    (out_col_o),
    .frame_done_i (frame_done_o),
    .run_last_i   (run_last_o),
    .cfg_valid_i,
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic [7:0] rand_level();
    int p;
    p = $urandom_range(99);
    if (p < 10) return 8'h00;
    if (p < 20) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic bb3_pkg::pix_t rand_pixel();
    return {rand_level(), rand_level(), rand_level()};
  endfunction

  function automatic bb3_pkg::pix_t test_pattern(input int k);
    case (k % 5)
      0:       return {8'h00, 8'h00, 8'h00};
      1:       return {8'hFF, 8'hFF, 8'hFF};
      2:       return {8'h55, 8'hAA, 8'hFF};
      3:       return {8'hAA, 8'h55, 8'h00};
      default: return {8'hFF, 8'h00, 8'h80};
    endcase
  endfunction

  // called at a rising edge; returns at the edge that takes the word
  task automatic send_word(input logic op, input bb3_pkg::pix_t px);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    red_in_i   <= px.r;
    green_in_i <= px.g;
    blue_in_i  <= px.b;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic hold_until_empty();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // words that give no result may still be in flight
  task automatic wait_idle();
    hold_until_empty();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [DataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input int width_val, input int height_val);
    wait_idle();
    if ($urandom_range(1)) begin
      write_reg(bb3_pkg::CfgFrameWidth, DataW'(width_val));
      write_reg(bb3_pkg::CfgFrameHeight, DataW'(height_val));
    end else begin
      write_reg(bb3_pkg::CfgFrameHeight, DataW'(height_val));
      write_reg(bb3_pkg::CfgFrameWidth, DataW'(width_val));
    end
    if ($urandom_range(9) == 0)
      write_reg(IdxW'($urandom_range(int'(bb3_pkg::CfgFrameHeight) + 1, LastCfgIdx)),
                DataW'($urandom));
  endtask

  // cut_at >= 0 stops the frame early after that many words
  task automatic run_frame(input int w, input int h, input int cut_at);
    int total, k;
    total = w * h;
    for (k = 0; k < total; k++) begin
      if (cut_at == k) return;
      if ($urandom_range(99) < 4) send_word(bb3_pkg::OpDrain, rand_pixel());
      if ($urandom_range(199) == 0) hold_until_empty();
      send_word(bb3_pkg::OpPixel, rand_pixel());
      words_sent++;
    end
    for (k = 0; k < w; k++) begin
      if (cut_at == total + k) return;
      if ($urandom_range(99) < 4) send_word(bb3_pkg::OpPixel, rand_pixel());
      send_word(bb3_pkg::OpDrain, rand_pixel());
      words_sent++;
    end
    if ($urandom_range(9) == 0) send_word(bb3_pkg::OpDrain, rand_pixel());
  endtask

  initial begin : sink
    int p, len;
    @(posedge clk_i);
    forever begin
      p = $urandom_range(99);
      if (p < 55) begin
        out_ready_i <= 1'b1;
        len = $urandom_range(1, 4);
      end else if (p < 65) begin
        out_ready_i <= 1'b1;
        len = $urandom_range(20, 60);
      end else if (p < 95) begin
        out_ready_i <= 1'b0;
        len = $urandom_range(1, 3);
      end else begin
        out_ready_i <= 1'b0;
        len = $urandom_range(10, 30);
      end
      repeat (len) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    int k, w, h, cut, p;
    burst = 1'b0;
    words_sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // 3x3 frame: corner, edge and center neighborhoods
    configure(3, 3);
    send_word(bb3_pkg::OpDrain, rand_pixel());
    for (k = 0; k < 9; k++) begin
      if (k == 5) hold_until_empty();
      send_word(bb3_pkg::OpPixel, test_pattern(k));
    end
    send_word(bb3_pkg::OpPixel, rand_pixel());
    for (k = 0; k < 3; k++) send_word(bb3_pkg::OpDrain, rand_pixel());
    send_word(bb3_pkg::OpDrain, rand_pixel());

    configure(1, 1);
    send_word(bb3_pkg::OpPixel, {8'hFF, 8'h80, 8'h01});
    send_word(bb3_pkg::OpDrain, rand_pixel());

    configure(1, 3);
    for (k = 0; k < 3; k++) send_word(bb3_pkg::OpPixel, test_pattern(k + 1));
    send_word(bb3_pkg::OpDrain, rand_pixel());

    // saturating sizes: width above the store depth with zero height, then zero width with height above the maximum
    configure(2047, 0);
    run_frame(1024, 1, 40);
    configure(0, 8191);
    run_frame(1, 4096, 40);
    wait_idle();
    write_reg(IdxW'(LastCfgIdx), DataW'($urandom));
    configure(1024, 4096);
    run_frame(1024, 4096, 10);

    words_sent = 0;
    while (words_sent < RandomWords) begin
      p = $urandom_range(99);
      if (p < 70) w = $urandom_range(1, 6);
      else if (p < 90) w = $urandom_range(7, 20);
      else w = $urandom_range(21, 64);
      h = ($urandom_range(99) < 80) ? $urandom_range(1, 5) : $urandom_range(6, 12);
      cut = ($urandom_range(9) == 0) ? $urandom_range(0, w * h + w - 1) : -1;
      burst = ($urandom_range(4) == 0);
      // bits above the width register are dropped by the block
      configure((((w == 1) && $urandom_range(1)) ? 0 : w) | ($urandom_range(3) << bb3_pkg::FwW),
                ((h == 1) && $urandom_range(1)) ? 0 : h);
      run_frame(w, h, cut);
    end

    hold_until_empty();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("box_blur_3x3_stream_top test passed");
    end else begin
      $display("box_blur_3x3_stream_top test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("box_blur_3x3_stream_top test failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/bb3_pkg.sv
sv/box_blur_3x3_stream_top.sv
sv/bb3_check.sv
verif/box_blur_3x3_stream_checker.sv
verif/tb.sv
